>>> sv/csle_pkg.sv
// Package for the cursor sequence list engine: sizes, command and status codes,
// sequencer states and the structs passed between the sequencer, store and top level.
// No dependencies.
package csle_pkg;

	// List capacity and derived widths
	localparam int DEPTH = 32;
	localparam int AW    = $clog2(DEPTH);      // item address / cursor
	localparam int CW    = $clog2(DEPTH + 1);  // item count, 0..DEPTH
	localparam int DW    = 32;                 // item word

	typedef enum logic [3:0] {
		ACT_START    = 4'd0,
		ACT_END      = 4'd1,
		ACT_ADVANCE  = 4'd2,
		ACT_INSERT   = 4'd3,
		ACT_ATTACH   = 4'd4,
		ACT_REMOVE   = 4'd5,
		ACT_PUSH_FR  = 4'd6,
		ACT_PUSH_BK  = 4'd7,
		ACT_POP_FR   = 4'd8,
		ACT_READ     = 4'd9
	} action_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_NOCUR = 3'd2,
		ST_EMPTY = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PUT,
		S_RD_IDX,
		S_RD_CUR,
		S_FIN
	} seq_state_t;

	// Store access for one cycle: one write port, one read port
	typedef struct packed {
		logic                 we;
		logic [AW-1:0]        waddr;
		logic signed [DW-1:0] wdata;
		logic [AW-1:0]        raddr;
	} mem_req_t;

	// Finished command, valid while fin is high
	typedef struct packed {
		logic                 fin;
		status_t              status;
		logic                 has_cur;
		logic [CW-1:0]        count;
		logic signed [DW-1:0] cur_value;
		logic signed [DW-1:0] read_value;
	} seq_rsp_t;

endpackage

>>> sv/csle_mem.sv
// Item store of the cursor sequence list engine: DEPTH words, one write and
// one registered read per cycle. Depends on csle_pkg.
module csle_mem (
	input  logic                          clk,
	input  csle_pkg::mem_req_t            req,
	output logic signed [csle_pkg::DW-1:0] rd_data
);
	import csle_pkg::*;

	logic signed [DW-1:0] mem_q [DEPTH];
	logic signed [DW-1:0] rd_data_q;

	// Write port and registered read port (read returns the old word on a collision)
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem_q[req.raddr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/csle_seq.sv
// Command sequencer of the cursor sequence list engine: decodes a command,
// holds cursor and count, and moves items one per cycle through an address
// stepper. Depends on csle_pkg.
module csle_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [3:0]                     action,
	input  logic signed [csle_pkg::DW-1:0] entry_value,
	input  logic [4:0]                     read_index,
	input  logic signed [csle_pkg::DW-1:0] rd_data,
	output logic                           busy,
	output csle_pkg::mem_req_t             mem_req,
	output csle_pkg::seq_rsp_t             rsp
);
	import csle_pkg::*;

	seq_state_t           state_q, state_d;
	logic [AW-1:0]        cursor_q;
	logic [CW-1:0]        count_q;
	status_t              status_q;
	logic [CW-1:0]        mv_q;
	logic [AW-1:0]        rp_q;
	logic [AW-1:0]        wp_q;
	logic                 pend_q;
	logic                 up_q;
	logic                 put_q;
	logic [AW-1:0]        pos_q;
	logic                 rd_idx_q;
	logic [AW-1:0]        ridx_q;
	logic signed [DW-1:0] entry_q;
	logic signed [DW-1:0] readv_q;

	logic                 accept;
	logic                 cur;
	logic                 full;
	logic [CW-1:0]        pos_w;
	status_t              d_status;
	logic [AW-1:0]        d_cursor;
	logic [CW-1:0]        d_count;
	logic [CW-1:0]        d_mv;
	logic [AW-1:0]        d_rp;
	logic                 d_up;
	logic                 d_put;
	logic                 d_rd;
	logic [AW-1:0]        step;
	logic                 has_cur;

	assign accept  = start && (state_q == S_IDLE);
	assign cur     = CW'(cursor_q) < count_q;
	assign full    = count_q >= CW'(DEPTH);
	assign has_cur = cur;

	// Command decode: new cursor and count, plus the move job for the sequencer
	always_comb begin
		d_status = ST_OK;
		d_cursor = cursor_q;
		d_count  = count_q;
		d_mv     = '0;
		d_rp     = '0;
		d_up     = 1'b0;
		d_put    = 1'b0;
		d_rd     = 1'b0;
		pos_w    = '0;
		case (action_t'(action))
			ACT_START: begin
				d_cursor = '0;
			end
			ACT_END: begin
				d_cursor = (count_q != '0) ? AW'(count_q - 1'b1) : '0;
			end
			ACT_ADVANCE: begin
				if (!cur) begin
					d_status = ST_NOCUR;
				end else if (cursor_q != AW'(DEPTH - 1)) begin
					d_cursor = cursor_q + 1'b1;
				end
			end
			ACT_INSERT, ACT_ATTACH, ACT_PUSH_FR, ACT_PUSH_BK: begin
				if (full) begin
					d_status = ST_FULL;
				end else begin
					case (action_t'(action))
						ACT_INSERT:  pos_w = cur ? CW'(cursor_q) : '0;
						ACT_ATTACH:  pos_w = cur ? CW'(cursor_q) + 1'b1 : count_q;
						ACT_PUSH_BK: pos_w = count_q;
						default:     pos_w = '0;
					endcase
					d_cursor = AW'(pos_w);
					d_mv     = count_q - pos_w;
					d_rp     = AW'(count_q - 1'b1);
					d_up     = 1'b1;
					d_put    = 1'b1;
					d_count  = count_q + 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (!cur) begin
					d_status = ST_NOCUR;
				end else begin
					d_mv    = count_q - CW'(cursor_q) - 1'b1;
					d_rp    = AW'(CW'(cursor_q) + 1'b1);
					d_count = count_q - 1'b1;
				end
			end
			ACT_POP_FR: begin
				if (count_q == '0) begin
					d_status = ST_EMPTY;
				end else begin
					d_mv     = count_q - 1'b1;
					d_rp     = AW'(1);
					d_count  = count_q - 1'b1;
					d_cursor = '0;
				end
			end
			ACT_READ: begin
				if (CW'(read_index) < count_q) begin
					d_rd = 1'b1;
				end else begin
					d_status = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	// Address stepper: write address of the word read this cycle
	assign step = up_q ? rp_q + 1'b1 : rp_q - 1'b1;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (d_mv != '0) begin
						state_d = S_SHIFT;
					end else if (d_put) begin
						state_d = S_PUT;
					end else if (d_rd) begin
						state_d = S_RD_IDX;
					end else begin
						state_d = S_RD_CUR;
					end
				end
			end
			S_SHIFT: begin
				if (mv_q == '0) begin
					state_d = put_q ? S_PUT : S_RD_CUR;
				end
			end
			S_PUT:    state_d = S_RD_CUR;
			S_RD_IDX: state_d = S_RD_CUR;
			S_RD_CUR: state_d = S_FIN;
			S_FIN:    state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs: store access and response
	always_comb begin
		busy          = (state_q != S_IDLE);
		mem_req.we    = ((state_q == S_SHIFT) && pend_q) || (state_q == S_PUT);
		mem_req.waddr = (state_q == S_PUT) ? pos_q : wp_q;
		mem_req.wdata = (state_q == S_PUT) ? entry_q : rd_data;
		case (state_q)
			S_RD_IDX: mem_req.raddr = ridx_q;
			S_RD_CUR: mem_req.raddr = cursor_q;
			default:  mem_req.raddr = rp_q;
		endcase
		rsp.fin        = (state_q == S_FIN);
		rsp.status     = status_q;
		rsp.has_cur    = has_cur;
		rsp.count      = count_q;
		rsp.cur_value  = has_cur ? rd_data : '0;
		rsp.read_value = rd_idx_q ? readv_q : '0;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cursor_q <= '0;
			count_q  <= '0;
			status_q <= ST_OK;
			mv_q     <= '0;
			pend_q   <= 1'b0;
			up_q     <= 1'b0;
			put_q    <= 1'b0;
			rd_idx_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cursor_q <= d_cursor;
				count_q  <= d_count;
				status_q <= d_status;
				mv_q     <= d_mv;
				pend_q   <= 1'b0;
				up_q     <= d_up;
				put_q    <= d_put;
				rd_idx_q <= d_rd;
			end else if (state_q == S_SHIFT) begin
				if (mv_q != '0) begin
					mv_q   <= mv_q - 1'b1;
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	// Addresses and data words; reads walk against the direction items move
	always_ff @(posedge clk) begin
		if (accept) begin
			rp_q    <= d_rp;
			pos_q   <= d_cursor;
			ridx_q  <= AW'(read_index);
			entry_q <= entry_value;
		end else if ((state_q == S_SHIFT) && (mv_q != '0)) begin
			rp_q <= up_q ? rp_q - 1'b1 : rp_q + 1'b1;
			wp_q <= step;
		end
		if ((state_q == S_RD_CUR) && rd_idx_q) begin
			readv_q <= rd_data;
		end
	end

	// Checks
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("item count above capacity");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (state_q == S_IDLE))
		else $error("finish not followed by idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not start");

	a_shift_pend: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SHIFT) && (mv_q != '0)) |=> pend_q)
		else $error("moved word lost");

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SHIFT) && pend_q && (mv_q != '0)) |-> (wp_q != rp_q))
		else $error("shift write hits pending read");

endmodule

>>> sv/cursor_sequence_list_engine.sv
// Top level of the cursor sequence list engine: sequencer, item store and
// result registers. Depends on csle_pkg, csle_mem, csle_seq.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  command   | start, busy          | action, entry_value, read_index
//  result    | done (1-cycle pulse) | current_value, has_current, item_count,
//            |                      | read_value, status
//
// A command passes through SHIFT while items move, PUT for a write, RD_IDX for a read
// by index, then RD_CUR and FIN, and done is registered from FIN;
// one read and one write port shift one item per cycle.
// busy is high from the accepting edge until the cycle before done.
// arst_n clears cursor, count and sequencer; store contents are left as they are.
// done is not held: the receiver takes the result in its single cycle.
module cursor_sequence_list_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [3:0]                     action,
	input  logic signed [31:0]             entry_value,
	input  logic [4:0]                     read_index,
	output logic                           done,
	output logic signed [31:0]             current_value,
	output logic                           has_current,
	output logic [5:0]                     item_count,
	output logic signed [31:0]             read_value,
	output logic [2:0]                     status
);
	import csle_pkg::*;

	mem_req_t             mem_req;
	seq_rsp_t             rsp;
	logic signed [DW-1:0] rd_data;

	logic                 done_q;
	logic signed [DW-1:0] cur_value_q;
	logic                 has_cur_q;
	logic [CW-1:0]        count_q;
	logic signed [DW-1:0] read_value_q;
	status_t              status_q;

	csle_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.entry_value (entry_value),
		.read_index  (read_index),
		.rd_data     (rd_data),
		.busy        (busy),
		.mem_req     (mem_req),
		.rsp         (rsp)
	);

	csle_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp.fin;
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (rsp.fin) begin
			cur_value_q  <= rsp.cur_value;
			has_cur_q    <= rsp.has_cur;
			count_q      <= rsp.count;
			read_value_q <= rsp.read_value;
			status_q     <= rsp.status;
		end
	end

	assign done          = done_q;
	assign current_value = cur_value_q;
	assign has_current   = has_cur_q;
	assign item_count    = count_q;
	assign read_value    = read_value_q;
	assign status        = status_q;

endmodule
